@@ design/lcf_pkg.sv @@
package lcf_pkg;

	localparam int MAX_MODULES_DEFAULT = 8;
	localparam int DIGIT_ROWS = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int SEL_W = 8;
	localparam int COUNT_CFG_W = 4;

	localparam logic [3:0] REG_NOOP = 4'd0;
	localparam logic [3:0] REG_DIGIT0 = 4'd1;
	localparam logic [3:0] REG_INTENSITY = 4'd10;
	localparam logic [3:0] REG_SHUTDOWN = 4'd12;
	localparam logic [3:0] REG_LAST_ROW = 4'(DIGIT_ROWS);

	localparam logic [7:0] DP_BIT = 8'b1000_0000;
	localparam logic [7:0] CHAR_BASE = 8'd40;
	localparam logic [7:0] CHAR_MAX = 8'd122;
	localparam logic [7:0] CHAR_LOWER_A = 8'd97;
	localparam logic [7:0] CASE_FOLD = 8'd32;
	localparam logic [7:0] CHAR_ROM_SIZE = 8'd56;
	localparam logic [7:0] NIBBLE_LIMIT = 8'd16;
	localparam logic [7:0] POS_LIMIT = 8'd8;

	typedef enum logic [2:0] {
		ACT_ROW       = 3'd0,
		ACT_HEX       = 3'd1,
		ACT_CHAR      = 3'd2,
		ACT_INTENSITY = 3'd3,
		ACT_SHUTDOWN  = 3'd4,
		ACT_CLEAR     = 3'd5
	} lcf_action_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] module_select;
		logic [7:0] position;
		logic [7:0] value;
		logic       decimal_point;
	} lcf_in_t;

	typedef struct packed {
		logic [3:0] register_address;
		logic [7:0] data_byte;
		logic       end_of_frame;
		logic       end_of_command;
	} lcf_out_t;

	typedef struct packed {
		logic [3:0]       reg_addr;
		logic [7:0]       data;
		logic [SEL_W-1:0] sel;
		logic             clear;
	} lcf_cmd_t;

	typedef struct packed {
		logic busy;
		logic last_pair;
	} lcf_back_status_t;

	function automatic logic [7:0] hex_seg(input logic [3:0] idx);
		logic [7:0] s;
		case (idx)
			4'h0: s = 8'h7E;
			4'h1: s = 8'h30;
			4'h2: s = 8'h6D;
			4'h3: s = 8'h79;
			4'h4: s = 8'h33;
			4'h5: s = 8'h5B;
			4'h6: s = 8'h5F;
			4'h7: s = 8'h70;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h7B;
			4'hA: s = 8'h77;
			4'hB: s = 8'h1F;
			4'hC: s = 8'h0D;
			4'hD: s = 8'h3D;
			4'hE: s = 8'h4F;
			4'hF: s = 8'h47;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] char_seg(input logic [5:0] idx);
		logic [7:0] s;
		case (idx)
			6'd4: s = 8'h80;
			6'd5: s = 8'h01;
			6'd6: s = 8'h80;
			6'd8: s = 8'h7E;
			6'd9: s = 8'h30;
			6'd10: s = 8'h6D;
			6'd11: s = 8'h79;
			6'd12: s = 8'h33;
			6'd13: s = 8'h5B;
			6'd14: s = 8'h5F;
			6'd15: s = 8'h70;
			6'd16: s = 8'h7F;
			6'd17: s = 8'h7B;
			6'd25: s = 8'h77;
			6'd26: s = 8'h1F;
			6'd27: s = 8'h0D;
			6'd28: s = 8'h3D;
			6'd29: s = 8'h4F;
			6'd30: s = 8'h47;
			6'd32: s = 8'h37;
			6'd36: s = 8'h0E;
			6'd40: s = 8'h67;
			6'd55: s = 8'h08;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

@@ design/lcf_front.sv @@
module lcf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  lcf_pkg::lcf_in_t  cmd,
	output logic              push,
	output lcf_pkg::lcf_cmd_t push_data,
	input  logic              q_full
);
	import lcf_pkg::*;

	logic     s1_valid_q;
	lcf_cmd_t cmd_s1;
	lcf_cmd_t cls;
	logic     keep;
	logic     accept;
	logic [7:0] c;
	logic     pos_ok;

	always_comb begin
		pos_ok = cmd.position < POS_LIMIT;
		c = cmd.value;
		if (c < CHAR_BASE || c > CHAR_MAX) begin
			c = CHAR_BASE;
		end
		if (c >= CHAR_LOWER_A) begin
			c = c - CASE_FOLD;
		end
		c = c - CHAR_BASE;
		cls.sel = cmd.module_select;
		cls.clear = 1'b0;
		cls.reg_addr = REG_DIGIT0 + cmd.position[3:0];
		cls.data = 8'h00;
		keep = 1'b0;
		case (lcf_action_t'(cmd.action))
			ACT_ROW: begin
				keep = pos_ok;
				cls.data = cmd.value;
			end
			ACT_HEX: begin
				keep = pos_ok && (cmd.value < NIBBLE_LIMIT);
				cls.data = hex_seg(cmd.value[3:0]) | (cmd.decimal_point ? DP_BIT : 8'h00);
			end
			ACT_CHAR: begin
				keep = pos_ok && (c < CHAR_ROM_SIZE);
				cls.data = char_seg(c[5:0]) | (cmd.decimal_point ? DP_BIT : 8'h00);
			end
			ACT_INTENSITY: begin
				keep = cmd.value < NIBBLE_LIMIT;
				cls.reg_addr = REG_INTENSITY;
				cls.data = cmd.value;
			end
			ACT_SHUTDOWN: begin
				keep = 1'b1;
				cls.reg_addr = REG_SHUTDOWN;
				cls.data = cmd.value[0] ? 8'h00 : 8'h01;
			end
			ACT_CLEAR: begin
				keep = 1'b1;
				cls.reg_addr = REG_DIGIT0;
				cls.clear = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign cmd_stall = s1_valid_q && q_full;
	assign accept = cmd_valid && !cmd_stall;
	assign push = s1_valid_q && !q_full;
	assign push_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!s1_valid_q || push) begin
			s1_valid_q <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

endmodule

@@ design/lcf_queue.sv @@
module lcf_queue #(
	parameter int DEPTH = lcf_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcf_pkg::lcf_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output lcf_pkg::lcf_cmd_t pop_data,
	output logic              empty
);
	import lcf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcf_cmd_t          entry_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/lcf_back.sv @@
module lcf_back #(
	parameter int MAX_MODULES = lcf_pkg::MAX_MODULES_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(MAX_MODULES+1)-1:0]   eff_count,
	input  logic                               q_empty,
	input  lcf_pkg::lcf_cmd_t                  q_data,
	output logic                               pop,
	output logic                               res_valid,
	input  logic                               res_stall,
	output lcf_pkg::lcf_out_t                  res,
	output lcf_pkg::lcf_back_status_t          status
);
	import lcf_pkg::*;

	localparam int CW = $clog2(MAX_MODULES + 1);
	localparam int IW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

	logic          busy_q;
	lcf_cmd_t      cur_q;
	logic [IW-1:0] idx_q;
	logic          res_valid_q;
	lcf_out_t      res_q;

	lcf_out_t      pair;
	logic          hit;
	logic          last_idx;
	logic          last_pair;
	logic          out_ready;
	logic          advance;
	logic [CW-1:0] top_idx;

	always_comb begin
		top_idx = eff_count - 1'b1;
		last_idx = idx_q == '0;
		last_pair = last_idx && (!cur_q.clear || cur_q.reg_addr == REG_LAST_ROW);
		hit = (cur_q.sel >= SEL_W'(eff_count)) || (cur_q.sel == SEL_W'(idx_q));
		pair.register_address = hit ? cur_q.reg_addr : REG_NOOP;
		pair.data_byte = hit ? cur_q.data : 8'h00;
		pair.end_of_frame = last_idx;
		pair.end_of_command = last_pair;
		out_ready = !res_valid_q || !res_stall;
		advance = busy_q && out_ready;
		pop = !q_empty && (!busy_q || (advance && last_pair));
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
	assign status.busy = busy_q;
	assign status.last_pair = last_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && last_pair) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= pair;
		end
		if (pop) begin
			cur_q <= q_data;
			idx_q <= top_idx[IW-1:0];
		end else if (advance) begin
			if (last_idx) begin
				cur_q.reg_addr <= cur_q.reg_addr + 1'b1;
				idx_q <= top_idx[IW-1:0];
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

endmodule

@@ design/led_display_command_framer.sv @@
// Turns display commands into register/data word pairs for a chain of LED
// driver chips, one pair per chained module per frame, last module first.
// The command channel (cmd_valid, cmd_stall, cmd) takes one beat whenever
// cmd_valid is high and cmd_stall is low; commands that are malformed are
// dropped and give no beats. The result channel (res_valid, res_stall, res)
// delivers one pair per beat; end_of_frame marks the pair for module 0 and
// end_of_command the last pair of the command.
// A command takes module_count beats, or eight frames of module_count beats
// for clear, set by the single output pair each cycle while res_stall is low.
// From idle, an accepted beat passes the front stage, queue, command and
// output registers to its first pair; a four-entry queue lets new commands
// enter while pairs of earlier ones are still going out. The module count is
// written through cfg_valid, cfg_ready and cfg_data; the user must write it
// only while the block is idle (not enforced). A count of zero acts as one
// and counts above the chain maximum are clipped. Reset sets the count to
// one and empties the queue and output register. While res_stall is high
// the current pair holds and the queue fills, after which cmd_stall rises.
module led_display_command_framer #(
	parameter int MAX_MODULES = lcf_pkg::MAX_MODULES_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  lcf_pkg::lcf_in_t    cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output lcf_pkg::lcf_out_t   res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [lcf_pkg::COUNT_CFG_W-1:0] cfg_data
);
	import lcf_pkg::*;

	localparam int CW = $clog2(MAX_MODULES + 1);

	logic [COUNT_CFG_W-1:0] count_q;
	logic [CW-1:0]          eff_count;
	logic                   push;
	lcf_cmd_t               push_data;
	logic                   q_full;
	logic                   pop;
	lcf_cmd_t               pop_data;
	logic                   q_empty;
	lcf_back_status_t       status;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (count_q == '0) begin
			eff_count = CW'(1);
		end else if (32'(count_q) > MAX_MODULES) begin
			eff_count = CW'(MAX_MODULES);
		end else begin
			eff_count = CW'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	lcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	lcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	lcf_back #(
		.MAX_MODULES (MAX_MODULES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_count (eff_count),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res.end_of_command |=> res_valid)
		else $error("pair missing inside a command");

	a_eoc_on_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.end_of_command || res.end_of_frame))
		else $error("command ended before its frame ended");

	a_no_spurious_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!status.busy && q_empty && (!res_valid || !res_stall) |=> !res_valid)
		else $error("pair emitted with no command pending");

	a_pop_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!status.busy || (status.last_pair && (!res_valid || !res_stall))))
		else $error("queue popped while a command was still in progress");
`endif

endmodule

@@ dv/tb_led_display_command_framer.sv @@
module tb_led_display_command_framer;
	timeunit 1ns;
	timeprecision 1ps;

	import lcf_pkg::*;

	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int SETTLE_CYCLES = 24;
	localparam int IDLE_PERCENT = 36;

	class display_frame_scoreboard;
		lcf_out_t pending_pairs[$];
		int unsigned modules = 1;
		int unsigned errors = 0;
		logic [7:0] hex_segments [0:15] = '{
			8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
			8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47
		};
		logic [7:0] char_segments [0:55] = '{
			8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h01, 8'h80, 8'h00,
			8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
			8'h7F, 8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h00,
			8'h37, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h00, 8'h00,
			8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08
		};

		function void set_module_count(logic [COUNT_CFG_W-1:0] setting);
			if (setting == 0)
				modules = 1;
			else if (setting > MAX_MODULES_DEFAULT)
				modules = MAX_MODULES_DEFAULT;
			else
				modules = setting;
		endfunction

		function int unsigned outstanding();
			return pending_pairs.size();
		endfunction

		function void push_frame(logic [3:0] reg_addr, logic [7:0] data, logic [7:0] sel,
				bit last_frame);
			lcf_out_t pair;
			bit hit;
			for (int i = modules - 1; i >= 0; i--) begin
				hit = (sel >= modules) || (sel == i);
				pair.register_address = hit ? reg_addr : REG_NOOP;
				pair.data_byte = hit ? data : 8'h00;
				pair.end_of_frame = (i == 0);
				pair.end_of_command = last_frame && (i == 0);
				pending_pairs.push_back(pair);
			end
		endfunction

		function void note_command(lcf_in_t c);
			logic [3:0] row_reg;
			logic [7:0] code;
			logic [7:0] segs;
			bit pos_ok;
			row_reg = REG_DIGIT0 + c.position[3:0];
			pos_ok = c.position < POS_LIMIT;
			case (c.action)
				ACT_ROW: begin
					if (pos_ok)
						push_frame(row_reg, c.value, c.module_select, 1'b1);
				end
				ACT_HEX: begin
					if (pos_ok && c.value < NIBBLE_LIMIT) begin
						segs = hex_segments[c.value[3:0]];
						if (c.decimal_point)
							segs = segs | DP_BIT;
						push_frame(row_reg, segs, c.module_select, 1'b1);
					end
				end
				ACT_CHAR: begin
					code = c.value;
					if (code < CHAR_BASE || code > CHAR_MAX)
						code = CHAR_BASE;
					if (code >= CHAR_LOWER_A)
						code = code - CASE_FOLD;
					code = code - CHAR_BASE;
					if (pos_ok && code < CHAR_ROM_SIZE) begin
						segs = char_segments[code];
						if (c.decimal_point)
							segs = segs | DP_BIT;
						push_frame(row_reg, segs, c.module_select, 1'b1);
					end
				end
				ACT_INTENSITY: begin
					if (c.value < NIBBLE_LIMIT)
						push_frame(REG_INTENSITY, c.value, c.module_select, 1'b1);
				end
				ACT_SHUTDOWN: begin
					push_frame(REG_SHUTDOWN, c.value[0] ? 8'd0 : 8'd1, c.module_select, 1'b1);
				end
				ACT_CLEAR: begin
					for (int r = 0; r < DIGIT_ROWS; r++)
						push_frame(REG_DIGIT0 + 4'(r), 8'h00, c.module_select,
							r == DIGIT_ROWS - 1);
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, logic [7:0] got);
			if (^got === 1'bx || got != want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_pair(lcf_out_t got);
			lcf_out_t want;
			if (pending_pairs.size() == 0) begin
				$error("unexpected result beat: register_address %0d data_byte %0d",
					got.register_address, got.data_byte);
				errors++;
				return;
			end
			want = pending_pairs.pop_front();
			compare_field("register_address", want.register_address, got.register_address);
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("end_of_frame", want.end_of_frame, got.end_of_frame);
			compare_field("end_of_command", want.end_of_command, got.end_of_command);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	lcf_in_t cmd;
	logic res_valid;
	logic res_stall;
	lcf_out_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [COUNT_CFG_W-1:0] cfg_data;
	bit steady;

	display_frame_scoreboard frames = new();

	led_display_command_framer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		res_stall = 1'b0;
	end

	always @(negedge clk) begin
		res_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
			frames.check_pair(res);
	end

	function automatic lcf_in_t make_cmd(logic [2:0] action, logic [7:0] sel,
			logic [7:0] pos, logic [7:0] value, logic dp);
		lcf_in_t c;
		c.action = action;
		c.module_select = sel;
		c.position = pos;
		c.value = value;
		c.decimal_point = dp;
		return c;
	endfunction

	function automatic lcf_in_t random_cmd();
		lcf_in_t c;
		int unsigned pick;
		pick = $urandom_range(99);
		c.module_select = ($urandom_range(9) < 7) ? 8'($urandom_range(frames.modules))
			: 8'($urandom_range(255));
		c.position = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
		c.value = 8'($urandom_range(255));
		c.decimal_point = 1'($urandom_range(1));
		if (pick < 20) begin
			c.action = ACT_ROW;
		end else if (pick < 38) begin
			c.action = ACT_HEX;
			if ($urandom_range(99) < 85)
				c.value = 8'($urandom_range(15));
		end else if (pick < 60) begin
			c.action = ACT_CHAR;
			case ($urandom_range(3))
				0: c.value = 8'("A") + 8'($urandom_range(25));
				1: c.value = CHAR_LOWER_A + 8'($urandom_range(25));
				2: c.value = 8'("0") + 8'($urandom_range(9));
				default: c.value = 8'($urandom_range(255));
			endcase
		end else if (pick < 70) begin
			c.action = ACT_INTENSITY;
			if ($urandom_range(99) < 85)
				c.value = 8'($urandom_range(15));
		end else if (pick < 80) begin
			c.action = ACT_SHUTDOWN;
		end else if (pick < 88) begin
			c.action = ACT_CLEAR;
		end else if (pick < 94) begin
			c.action = 3'($urandom_range(ACT_CLEAR));
			c.position = 8'($urandom_range(255));
		end else begin
			c.action = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
		end
		return c;
	endfunction

	task automatic send_command(lcf_in_t c);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (cmd_stall !== 1'b0);
		frames.note_command(c);
		@(negedge clk);
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (frames.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_module_count(logic [COUNT_CFG_W-1:0] setting);
		cfg_valid <= 1'b1;
		cfg_data <= setting;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		frames.set_module_count(setting);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		lcf_in_t directed[$];
		logic [COUNT_CFG_W-1:0] settings [PHASES] = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd6, 4'd1};
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed = '{
			make_cmd(ACT_ROW, 8'd0, 8'd0, 8'h00, 1'b0),
			make_cmd(ACT_ROW, 8'd7, 8'd7, 8'hFF, 1'b1),
			make_cmd(ACT_ROW, 8'd2, 8'd8, 8'h55, 1'b0),
			make_cmd(ACT_ROW, 8'd255, 8'd255, 8'hFF, 1'b1),
			make_cmd(ACT_HEX, 8'd255, 8'd3, 8'd0, 1'b0),
			make_cmd(ACT_HEX, 8'd8, 8'd7, 8'd15, 1'b1),
			make_cmd(ACT_HEX, 8'd1, 8'd1, 8'd16, 1'b0),
			make_cmd(ACT_HEX, 8'd1, 8'd255, 8'd10, 1'b0),
			make_cmd(ACT_CHAR, 8'd1, 8'd0, CHAR_LOWER_A, 1'b0),
			make_cmd(ACT_CHAR, 8'd4, 8'd5, 8'("Z"), 1'b1),
			make_cmd(ACT_CHAR, 8'd6, 8'd2, 8'("0"), 1'b0),
			make_cmd(ACT_CHAR, 8'd0, 8'd0, 8'd96, 1'b0),
			make_cmd(ACT_CHAR, 8'd3, 8'd4, 8'd39, 1'b0),
			make_cmd(ACT_CHAR, 8'd3, 8'd6, 8'd123, 1'b1),
			make_cmd(ACT_CHAR, 8'd9, 8'd1, 8'd255, 1'b1),
			make_cmd(ACT_CHAR, 8'd0, 8'd8, 8'("A"), 1'b0),
			make_cmd(ACT_INTENSITY, 8'd5, 8'd0, 8'd15, 1'b0),
			make_cmd(ACT_INTENSITY, 8'd5, 8'd0, 8'd16, 1'b0),
			make_cmd(ACT_SHUTDOWN, 8'd2, 8'd0, 8'd0, 1'b0),
			make_cmd(ACT_SHUTDOWN, 8'd0, 8'd200, 8'hFF, 1'b1),
			make_cmd(ACT_SHUTDOWN, 8'd255, 8'd0, 8'hFE, 1'b0),
			make_cmd(ACT_CLEAR, 8'd255, 8'd0, 8'h00, 1'b0),
			make_cmd(ACT_CLEAR, 8'd3, 8'd0, 8'h00, 1'b0),
			make_cmd(ACT_SPARE_LO, 8'd0, 8'd0, 8'h01, 1'b0),
			make_cmd(ACT_SPARE_HI, 8'd255, 8'd0, 8'h01, 1'b1)
		};

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			write_module_count(settings[p]);
			steady = (p == 1);
			if (p == 0)
				foreach (directed[i])
					send_command(directed[i]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Hold the command side off until the chain has emptied once mid-phase.
				if (p == 3 && n == ITEMS_PER_PHASE / 2)
					drain_results();
				send_command(random_cmd());
			end
		end
		steady = 1'b0;
		drain_results();

		if (frames.errors == 0 && frames.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
